[rtl/rms_pkg.sv]
// Shared types and constants of the rate-monotonic thread scheduler.
// Used by rms_cfg, the scheduler top and the testbench; depends on nothing else.
package rms_pkg;

  localparam int NUM_THREADS_DEF  = 7;
  localparam int TIMEOUT_BITS_DEF = 16;

  localparam int NUM_PERIOD_REGS  = 6;
  localparam int PERIOD_W         = 16;
  localparam int PIDX_W           = $clog2(NUM_PERIOD_REGS);
  localparam int CFG_IDX_W        = 3;
  localparam int PRIO_W           = 6;
  localparam int NONPERIODIC_PRIO = 33;
  localparam int NO_THREAD        = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_IDX = 3'd6;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_DELAY = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_IDLE_DELAY = 2'd1;
  localparam logic [1:0] ST_ZERO_DELAY = 2'd2;
  localparam logic [1:0] ST_BAD_START  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  thread_number;
    logic [15:0] delay_ticks;
  } sched_in_t;

  typedef struct packed {
    logic [2:0] run_thread;
    logic       switch_request;
    logic [5:0] ready_threads;
    logic [1:0] status;
  } sched_out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                periodic;
  } cfg_rd_t;

endpackage

[rtl/rms_alu.sv]
// Shared subtractor: decrements timeouts and does the period and rank compares.
// Depends on nothing.
module rms_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  // A borrow out means a_i < b_i.
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

[rtl/rms_tmem.sv]
// Per-thread timeout store: one write port, one read port with registered data.
// Depends on nothing.
module rms_tmem #(
  parameter int DEPTH = 6,
  parameter int W     = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/rms_cfg.sv]
// Period and periodic-mask registers with one read port addressed by thread.
// Depends on rms_pkg.
module rms_cfg #(
  parameter int NUM_THREADS = rms_pkg::NUM_THREADS_DEF,
  localparam int TW = ($clog2(NUM_THREADS) > 3) ? $clog2(NUM_THREADS) : 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [rms_pkg::PERIOD_W-1:0]   data_i,
  input  logic [TW-1:0]                  rd_thread_i,
  output rms_pkg::cfg_rd_t               rd_o
);
  import rms_pkg::*;

  logic [PERIOD_W-1:0]        period_q [NUM_PERIOD_REGS];
  logic [NUM_PERIOD_REGS-1:0] mask_q;
  logic [TW-1:0]              rd_pos;
  logic [PIDX_W-1:0]          rd_sel;
  logic                       rd_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PERIOD_REGS; k++) begin
        period_q[k] <= '0;
      end
      mask_q <= '0;
    end else if (we_i) begin
      if (index_i < CFG_IDX_W'(NUM_PERIOD_REGS)) begin
        period_q[PIDX_W'(index_i)] <= data_i;
      end else if (index_i == CFG_MASK_IDX) begin
        mask_q <= data_i[NUM_PERIOD_REGS-1:0];
      end
    end
  end

  // Threads without a register read as aperiodic with period zero.
  assign rd_pos      = rd_thread_i - TW'(1);
  assign rd_sel      = rd_pos[PIDX_W-1:0];
  assign rd_in_range = (rd_thread_i != '0) && (rd_thread_i <= TW'(NUM_PERIOD_REGS));

  always_comb begin
    rd_o.period   = rd_in_range ? period_q[rd_sel] : '0;
    rd_o.periodic = rd_in_range & mask_q[rd_sel];
  end

endmodule

[rtl/rate_monotonic_thread_scheduler.sv]
// Rate-monotonic thread scheduler for the idle thread 0 and NUM_THREADS-1 workers.
// A small sequencer drives one shared subtractor (rms_alu) over the timeout
// store (rms_tmem) and the period registers (rms_cfg).
// Depends on rms_pkg, rms_alu, rms_tmem and rms_cfg.
//
// Usage: pulse start with an operation on in_i while busy is low; the item is
// taken at that edge and busy rises. One result beat follows on result_o with
// result_valid_o high for exactly one cycle; the receiver cannot stall it,
// and busy is already low in that cycle, so a new item may start at once.
// Config writes use cfg_valid_i/cfg_ready_o; the user must issue them only while
// the block is idle; the block does not enforce it, cfg_ready_o is always high.
// A delay or start goes straight to the priority scan; a tick first walks the
// timeout store thread by thread (read, then decrement and write back).
// The priority scan covers threads 1..NUM_THREADS/2: a thread that is not ready
// is skipped, a ready aperiodic thread goes on to the compare step, and a ready
// periodic one first has its rank counted by comparing its period against every
// worker thread through the shared subtractor, before the output step.
// Reset clears the ready, delayed and started sets and every register but pi_q
// and res_q, sets the current thread to "none yet"; no clearing pass is needed.
module rate_monotonic_thread_scheduler #(
  parameter int NUM_THREADS  = rms_pkg::NUM_THREADS_DEF,
  parameter int TIMEOUT_BITS = rms_pkg::TIMEOUT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rms_pkg::sched_in_t            in_i,
  output logic                          result_valid_o,
  output rms_pkg::sched_out_t           result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rms_pkg::PERIOD_W-1:0]  cfg_data_i
);
  import rms_pkg::*;

  localparam int TW    = ($clog2(NUM_THREADS) > 3) ? $clog2(NUM_THREADS) : 3;
  localparam int NW    = NUM_THREADS - 1;
  localparam int AW    = $clog2(NW);
  localparam int SW    = $clog2(NUM_THREADS);
  localparam int HALF  = NUM_THREADS / 2;
  localparam int ALU_W = (TIMEOUT_BITS > PERIOD_W) ? TIMEOUT_BITS : PERIOD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRD  = 3'd1;
  localparam logic [2:0] S_TWR  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [1:0]             status_q, status_d;
  logic [TW-1:0]          idx_q, idx_d;
  logic [TW-1:0]          j_q, j_d;
  logic [TW-1:0]          best_q, best_d;
  logic [TW-1:0]          cur_q, cur_d;
  logic [PRIO_W-1:0]      cnt_q, cnt_d;
  logic [PRIO_W-1:0]      bestp_q, bestp_d;
  logic [PERIOD_W-1:0]    pi_q, pi_d;
  logic [NW-1:0]          ready_q, ready_d;
  logic [NW-1:0]          delayed_q, delayed_d;
  logic [NUM_THREADS-1:0] started_q, started_d;
  logic                   valid_q, valid_d;
  sched_out_t             res_q, res_d;

  logic                    accept;
  logic [AW-1:0]           idx_pos;
  logic [AW-1:0]           cur_pos;
  logic [AW-1:0]           tn_rpos;
  logic [SW-1:0]           tn_pos;
  logic                    tn_in_range;
  logic                    cur_bad;
  logic [TIMEOUT_BITS-1:0] ticks;
  logic [TIMEOUT_BITS-1:0] dec;
  logic [TW-1:0]           upper_next;
  logic [TW-1:0]           chosen_thread;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [TIMEOUT_BITS-1:0] mem_wdata;
  logic [TIMEOUT_BITS-1:0] mem_rdata;

  logic [ALU_W-1:0]        alu_a, alu_b, alu_diff;
  logic                    alu_borrow;

  logic [TW-1:0]           cfg_thread;
  cfg_rd_t                 cfg_rd;

  rms_alu #(.W(ALU_W)) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  rms_tmem #(.DEPTH(NW), .W(TIMEOUT_BITS)) u_tmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_pos),
    .rdata_o (mem_rdata)
  );

  rms_cfg #(.NUM_THREADS(NUM_THREADS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (cfg_valid_i & cfg_ready_o),
    .index_i     (cfg_index_i),
    .data_i      (cfg_data_i),
    .rd_thread_i (cfg_thread),
    .rd_o        (cfg_rd)
  );

  assign busy           = (state_q != S_IDLE);
  assign accept         = start & ~busy;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  assign idx_pos       = AW'(idx_q - TW'(1));
  assign cur_pos       = AW'(cur_q - TW'(1));
  assign tn_rpos       = AW'(32'(in_i.thread_number) - 32'd1);
  assign tn_pos        = SW'(in_i.thread_number);
  assign tn_in_range   = 32'(in_i.thread_number) < 32'(NUM_THREADS);
  assign cur_bad       = (cur_q == '0) || (32'(cur_q) >= 32'(NUM_THREADS));
  assign ticks         = TIMEOUT_BITS'(in_i.delay_ticks);
  assign dec           = alu_diff[TIMEOUT_BITS-1:0];
  assign cfg_thread    = (state_q == S_CNT) ? j_q : idx_q;
  assign chosen_thread = (best_q != '0) ? best_q : upper_next;

  // Highest-indexed ready thread of the upper half.
  always_comb begin
    upper_next = '0;
    for (int k = HALF + 1; k < NUM_THREADS; k++) begin
      if (ready_q[k-1]) begin
        upper_next = TW'(k);
      end
    end
  end

  always_comb begin
    case (state_q)
      S_TWR: begin
        alu_a = ALU_W'(mem_rdata);
        alu_b = ALU_W'(1);
      end
      S_CNT: begin
        alu_a = ALU_W'(cfg_rd.period);
        alu_b = ALU_W'(pi_q);
      end
      S_CMP: begin
        alu_a = ALU_W'(cnt_q);
        alu_b = ALU_W'(bestp_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    idx_d     = idx_q;
    j_d       = j_q;
    best_d    = best_q;
    bestp_d   = bestp_q;
    cnt_d     = cnt_q;
    pi_d      = pi_q;
    cur_d     = cur_q;
    ready_d   = ready_q;
    delayed_d = delayed_q;
    started_d = started_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = idx_pos;
    mem_wdata = dec;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          idx_d    = TW'(1);
          best_d   = '0;
          bestp_d  = '1;
          state_d  = S_SCAN;
          case (in_i.operation)
            OP_DELAY: begin
              if (cur_bad) begin
                status_d = ST_IDLE_DELAY;
              end else if (ticks == '0) begin
                status_d = ST_ZERO_DELAY;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = cur_pos;
                mem_wdata          = ticks;
                ready_d[cur_pos]   = 1'b0;
                delayed_d[cur_pos] = 1'b1;
              end
            end
            OP_START: begin
              if (!tn_in_range || started_q[tn_pos]) begin
                status_d = ST_BAD_START;
              end else begin
                started_d[tn_pos] = 1'b1;
                if (in_i.thread_number != '0) begin
                  ready_d[tn_rpos] = 1'b1;
                end
              end
            end
            default: begin
              // Ticks (and the unused operation code) walk every timeout first.
              state_d = S_TRD;
            end
          endcase
        end
      end
      S_TRD: begin
        state_d = S_TWR;
      end
      S_TWR: begin
        if (delayed_q[idx_pos]) begin
          mem_we = 1'b1;
          if (dec == '0) begin
            ready_d[idx_pos]   = 1'b1;
            delayed_d[idx_pos] = 1'b0;
          end
        end
        if (idx_q == TW'(NW)) begin
          idx_d   = TW'(1);
          best_d  = '0;
          bestp_d = '1;
          state_d = S_SCAN;
        end else begin
          idx_d   = idx_q + TW'(1);
          state_d = S_TRD;
        end
      end
      S_SCAN: begin
        if (ready_q[idx_pos]) begin
          if (cfg_rd.periodic) begin
            pi_d    = cfg_rd.period;
            j_d     = TW'(1);
            cnt_d   = PRIO_W'(1);
            state_d = S_CNT;
          end else begin
            cnt_d   = PRIO_W'(NONPERIODIC_PRIO);
            state_d = S_CMP;
          end
        end else if (idx_q == TW'(HALF)) begin
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end
      S_CNT: begin
        // Count periodic threads whose period is strictly shorter.
        if (cfg_rd.periodic && alu_borrow) begin
          cnt_d = cnt_q + PRIO_W'(1);
        end
        if (j_q == TW'(NW)) begin
          state_d = S_CMP;
        end else begin
          j_d = j_q + TW'(1);
        end
      end
      S_CMP: begin
        // Strict compare keeps the lower index on a tie.
        if (alu_borrow) begin
          best_d  = idx_q;
          bestp_d = cnt_q;
        end
        if (idx_q == TW'(HALF)) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + TW'(1);
          state_d = S_SCAN;
        end
      end
      S_OUT: begin
        valid_d              = 1'b1;
        res_d.run_thread     = 3'(chosen_thread);
        res_d.switch_request = (chosen_thread != cur_q);
        res_d.ready_threads  = 6'(ready_q);
        res_d.status         = status_q;
        if (status_q == ST_OK) begin
          cur_d = chosen_thread;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= ST_OK;
      idx_q     <= '0;
      j_q       <= '0;
      best_q    <= '0;
      bestp_q   <= '0;
      cnt_q     <= '0;
      cur_q     <= TW'(NO_THREAD);
      ready_q   <= '0;
      delayed_q <= '0;
      started_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      idx_q     <= idx_d;
      j_q       <= j_d;
      best_q    <= best_d;
      bestp_q   <= bestp_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      ready_q   <= ready_d;
      delayed_q <= delayed_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q  <= pi_d;
    res_q <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_ready_delayed_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q & delayed_q) == '0)
    else $error("a thread is both ready and delayed");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_beat_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(state_q == S_OUT))
    else $error("result beat outside the output step");

  a_error_keeps_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_OK) |-> $stable(cur_q))
    else $error("error item changed the current thread");
`endif

endmodule

[tb/rms_sched_checker.sv]
`timescale 1ns / 100ps
// Checker for the rate-monotonic thread scheduler: watches the command, result and
// register channels, predicts every result beat and compares it. Depends on rms_pkg.
module rms_sched_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  rms_pkg::sched_in_t            item_i,
  input  logic                          result_valid_i,
  input  rms_pkg::sched_out_t           result_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rms_pkg::PERIOD_W-1:0]  cfg_data_i,
  output int                            errors_o,
  output int                            waiting_o,
  output int                            checked_o
);
  import rms_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int WORKERS      = NUM_THREADS_DEF - 1;
  localparam int LOW_HALF     = NUM_THREADS_DEF / 2;
  localparam logic [2:0] IDLE_THREAD = 3'd0;

  logic [PERIOD_W-1:0]         period_q [1:NUM_PERIOD_REGS];
  logic [NUM_PERIOD_REGS-1:0]  periodic_q;
  logic [WORKERS-1:0]          ready_q;
  logic [WORKERS-1:0]          delayed_q;
  logic [NUM_THREADS_DEF-1:0]  started_q;
  logic [TIMEOUT_BITS_DEF-1:0] timeout_q [1:WORKERS];
  logic [2:0]                  running_q;
  sched_out_t                  expected_picks [$];

  function automatic int rm_priority(int k);
    int rank;
    if (k > NUM_PERIOD_REGS || !periodic_q[k-1]) return NONPERIODIC_PRIO;
    rank = 1;
    for (int j = 1; j <= NUM_PERIOD_REGS; j++)
      if (periodic_q[j-1] && period_q[j] < period_q[k]) rank++;
    return rank;
  endfunction

  // Ready low-half threads compete on priority; otherwise the highest ready
  // upper-half thread wins, and with nothing ready the idle thread runs.
  function automatic logic [2:0] pick_thread();
    int best;
    int best_prio;
    best = 0;
    best_prio = NONPERIODIC_PRIO + 1;
    for (int k = 1; k <= LOW_HALF; k++)
      if (ready_q[k-1] && rm_priority(k) < best_prio) begin
        best_prio = rm_priority(k);
        best = k;
      end
    if (best == 0)
      for (int k = LOW_HALF + 1; k < NUM_THREADS_DEF; k++)
        if (ready_q[k-1]) best = k;
    return 3'(best);
  endfunction

  function automatic sched_out_t schedule_step(sched_in_t item);
    sched_out_t res;
    logic [1:0] code;
    logic [2:0] chosen;
    code = ST_OK;
    case (item.operation)
      OP_DELAY: begin
        if (running_q == IDLE_THREAD || running_q >= NUM_THREADS_DEF) begin
          code = ST_IDLE_DELAY;
        end else if (item.delay_ticks == '0) begin
          code = ST_ZERO_DELAY;
        end else begin
          timeout_q[running_q]   = item.delay_ticks;
          ready_q[running_q-1]   = 1'b0;
          delayed_q[running_q-1] = 1'b1;
        end
      end
      OP_START: begin
        if (item.thread_number >= NUM_THREADS_DEF || started_q[item.thread_number]) begin
          code = ST_BAD_START;
        end else begin
          started_q[item.thread_number] = 1'b1;
          if (item.thread_number != IDLE_THREAD) ready_q[item.thread_number-1] = 1'b1;
        end
      end
      default: begin
        // Tick; the unused operation code behaves the same way.
        for (int k = 1; k <= WORKERS; k++)
          if (delayed_q[k-1]) begin
            timeout_q[k] = timeout_q[k] - 1'b1;
            if (timeout_q[k] == '0) begin
              ready_q[k-1]   = 1'b1;
              delayed_q[k-1] = 1'b0;
            end
          end
      end
    endcase
    chosen = pick_thread();
    res.run_thread     = chosen;
    res.switch_request = (chosen != running_q);
    res.ready_threads  = ready_q;
    res.status         = code;
    if (code == ST_OK) running_q = chosen;
    return res;
  endfunction

  task automatic flag_error(string what, logic [5:0] want, logic [5:0] got);
    errors_o++;
    if (errors_o <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [5:0] want, logic [5:0] got);
    if (got !== want) flag_error(what, want, got);
  endtask

  task automatic check_result(sched_out_t got);
    sched_out_t want;
    checked_o++;
    if (expected_picks.size() == 0) begin
      flag_error("unexpected result beat, run_thread", '0, got.run_thread);
      return;
    end
    want = expected_picks.pop_front();
    check_field("run_thread", want.run_thread, got.run_thread);
    check_field("switch_request", want.switch_request, got.switch_request);
    check_field("ready_threads", want.ready_threads, got.ready_threads);
    check_field("status", want.status, got.status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NUM_PERIOD_REGS; k++) period_q[k] = '0;
      for (int k = 1; k <= WORKERS; k++) timeout_q[k] = '0;
      periodic_q = '0;
      ready_q    = '0;
      delayed_q  = '0;
      started_q  = '0;
      running_q  = 3'(NO_THREAD);
      expected_picks.delete();
      errors_o   = 0;
      waiting_o  = 0;
      checked_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i < NUM_PERIOD_REGS) period_q[cfg_index_i + 1] = cfg_data_i;
        else if (cfg_index_i == CFG_MASK_IDX) periodic_q = cfg_data_i[NUM_PERIOD_REGS-1:0];
      end
      if (result_valid_i) check_result(result_i);
      if (start_i && !busy_i) expected_picks.push_back(schedule_step(item_i));
      waiting_o = expected_picks.size();
    end
  end

endmodule

[tb/tb_rate_monotonic_thread_scheduler.sv]
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, register settings and command beats.
// Depends on rms_pkg, rate_monotonic_thread_scheduler and rms_sched_checker.
module tb_rate_monotonic_thread_scheduler;
  import rms_pkg::*;

  localparam logic [1:0]           OP_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 216;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  sched_in_t            sched_in;
  logic                 result_valid_o;
  sched_out_t           sched_out;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;
  int                   fails;
  int                   waiting;
  int                   checked;
  int                   items_sent;
  int                   burst_left;
  int                   quiet_cycles;

  rate_monotonic_thread_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (sched_in),
    .result_valid_o (result_valid_o),
    .result_o       (sched_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  rms_sched_checker sched_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (sched_in),
    .result_valid_i (result_valid_o),
    .result_i       (sched_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (fails),
    .waiting_o      (waiting),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat on any channel for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic sched_in_t make_item(logic [1:0] op, logic [2:0] tn, logic [15:0] dt);
    sched_in_t it;
    it.operation     = op;
    it.thread_number = tn;
    it.delay_ticks   = dt;
    return it;
  endfunction

  // Mostly ticks and short sleeps so threads keep cycling through delay and wakeup;
  // starts are nearly all repeats by now, and zero delays are kept rare.
  function automatic sched_in_t random_item();
    sched_in_t it;
    int roll;
    roll = $urandom_range(99);
    it = make_item(OP_TICK, 3'($urandom), 16'($urandom));
    if (roll >= 48 && roll < 52) begin
      it.operation = OP_SPARE;
    end else if (roll >= 52 && roll < 57) begin
      it.operation = OP_START;
    end else if (roll >= 57) begin
      it.operation = OP_DELAY;
      if (roll < 60) it.delay_ticks = '0;
      else if (roll < 66) it.delay_ticks = 16'($urandom_range(64, 9));
      else it.delay_ticks = 16'($urandom_range(8, 1));
    end
    return it;
  endfunction

  function automatic logic [6*PERIOD_W-1:0] random_periods(int span);
    logic [6*PERIOD_W-1:0] p;
    for (int k = 0; k < NUM_PERIOD_REGS; k++) p[k*PERIOD_W +: PERIOD_W] = 16'($urandom_range(span));
    return p;
  endfunction

  // Holds start until the block takes the beat, then maybe ends the burst with a gap.
  task automatic push_item(input sched_in_t item);
    @(negedge clk_i);
    start    <= 1'b1;
    sched_in <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(48)) @(negedge clk_i);
      burst_left = ($urandom_range(9) == 0) ? 80 : $urandom_range(16, 1);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (waiting != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Thread 1 takes the lowest slice of the period vector.
  task automatic load_config(input logic [6*PERIOD_W-1:0] periods, input logic [15:0] mask);
    for (int k = 0; k < NUM_PERIOD_REGS; k++)
      write_reg(CFG_IDX_W'(k), periods[k*PERIOD_W +: PERIOD_W]);
    write_reg(CFG_MASK_IDX, mask);
  endtask

  initial begin
    int phase;
    rst_ni       = 1'b0;
    start        = 1'b0;
    sched_in     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    items_sent   = 0;
    burst_left   = 1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Thread 3 is aperiodic here, so it loses to the periodic low-half threads.
    load_config({16'h8000, 16'h0001, 16'h0000, 16'hFFFF, 16'h0010, 16'h0100}, 16'h003B);
    push_item(make_item(OP_DELAY, 3'd0, 16'd5));       // delay before any thread ran
    push_item(make_item(OP_TICK,  3'd7, 16'hFFFF));
    push_item(make_item(OP_SPARE, 3'd0, 16'h0000));
    push_item(make_item(OP_START, 3'd0, 16'd0));       // idle thread only
    push_item(make_item(OP_DELAY, 3'd0, 16'd3));       // delay from idle
    push_item(make_item(OP_START, 3'd7, 16'd0));       // no such thread
    push_item(make_item(OP_START, 3'd0, 16'd0));       // repeated start
    push_item(make_item(OP_START, 3'd5, 16'd0));
    push_item(make_item(OP_START, 3'd4, 16'd0));
    push_item(make_item(OP_START, 3'd6, 16'd0));
    push_item(make_item(OP_START, 3'd6, 16'd0));
    push_item(make_item(OP_START, 3'd3, 16'd0));
    push_item(make_item(OP_START, 3'd2, 16'd0));
    push_item(make_item(OP_START, 3'd1, 16'd0));
    push_item(make_item(OP_DELAY, 3'd7, 16'd0));       // zero delay
    push_item(make_item(OP_DELAY, 3'd0, 16'd1));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));
    push_item(make_item(OP_DELAY, 3'd0, 16'd2));
    push_item(make_item(OP_DELAY, 3'd0, 16'd3));
    push_item(make_item(OP_DELAY, 3'd0, 16'd1));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));

    for (phase = 1; phase <= PHASES; phase++) begin
      wait_all_results();
      case (phase)
        1: load_config({6{16'hFFFF}}, 16'h003F);          // all tied, lowest index wins
        2: load_config({6{16'h0000}}, 16'hFFC0);          // nothing periodic
        3: load_config(random_periods(7), 16'($urandom));
        4: begin
          load_config(random_periods(65535), 16'($urandom));
          write_reg(CFG_SPARE_IDX, 16'($urandom));
        end
        default: load_config({16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60},
                             16'($urandom_range(63)));
      endcase
      repeat (PHASE_ITEMS) begin
        push_item(random_item());
        if ($urandom_range(63) == 0) wait_all_results();
      end
    end

    // Longest sleeps last, since a thread put away this long never wakes again.
    push_item(make_item(OP_DELAY, 3'd0, 16'hFFFF));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));
    push_item(make_item(OP_DELAY, 3'd0, 16'h8000));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));
    push_item(make_item(OP_TICK,  3'd0, 16'd0));

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Ran %0d scheduler commands over %0d register settings; %0d result beats compared.",
             items_sent, PHASES + 1, checked);
    $display("Mismatches: %0d, results still outstanding: %0d", fails, waiting);
    if (fails == 0 && waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rms_pkg.sv
rtl/rms_alu.sv
rtl/rms_tmem.sv
rtl/rms_cfg.sv
rtl/rate_monotonic_thread_scheduler.sv
tb/rms_sched_checker.sv
tb/tb_rate_monotonic_thread_scheduler.sv
